[hdl/ccc_pkg.sv]
// shared types and codes for the connected component counter
package ccc_pkg;

    localparam logic [1:0] OP_ADD_EDGE = 2'd0;
    localparam logic [1:0] OP_COUNT    = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    localparam logic [6:0] COUNT_MAX     = 7'd127;
    localparam logic [6:0] VERTICES_INIT = 7'd64;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE_RD_A,
        ST_EDGE_WR_A,
        ST_EDGE_RD_B,
        ST_EDGE_WR_B,
        ST_SCAN,
        ST_PUSH,
        ST_POP,
        ST_ROW,
        ST_EXPAND
    } state_t;

endpackage

[hdl/connected_component_counter.sv]
// connected component counter: adjacency matrix in ram, depth-first walk with a ram stack
// add edge: busy through a read-modify-write of both endpoint rows; an edge outside the vertices in use is ignored
// clear: busy while all MAX_V rows are zeroed, one row per cycle on the adjacency ram port
// count: busy while each vertex in use is found by a scan or a push, then popped, its row read and expanded;
//   done pulses for a single cycle, as busy drops, with component_count
// reset: a clearing pass over all MAX_V rows of the adjacency ram runs before the first request
module connected_component_counter #(
    parameter int MAX_V = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] op,
    input  logic [5:0] vertex_a,
    input  logic [5:0] vertex_b,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,
    output logic       done,
    output logic [6:0] component_count
);

    localparam int AW = $clog2(MAX_V);
    localparam int DW = AW + 1;
    localparam int CW = (AW + 1 > 7) ? AW + 1 : 7;
    localparam logic [MAX_V-1:0] ONE = {{(MAX_V-1){1'b0}}, 1'b1};

    ccc_pkg::state_t state_reg, state_next;

    logic [6:0]       num_vertices_reg;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [DW-1:0]    depth_reg, depth_next;
    logic [6:0]       tally_reg, tally_next;
    logic             done_reg, done_next;
    logic [MAX_V-1:0] visited_reg, visited_next;
    logic [MAX_V-1:0] pend_reg, pend_next;
    logic [AW-1:0]    va_reg, va_next;
    logic [AW-1:0]    vb_reg, vb_next;

    logic [CW-1:0]    n_eff;
    logic [MAX_V-1:0] active;
    logic             accept;
    logic             edge_ok;

    logic             adj_we;
    logic [AW-1:0]    adj_waddr;
    logic [MAX_V-1:0] adj_wdata;
    logic [AW-1:0]    adj_raddr;
    logic [MAX_V-1:0] adj_rdata;

    logic             stk_we;
    logic [AW-1:0]    stk_waddr;
    logic [AW-1:0]    stk_wdata;
    logic [AW-1:0]    stk_raddr;
    logic [AW-1:0]    stk_rdata;

    logic [MAX_V-1:0] enc_in;
    logic             enc_found;
    logic [AW-1:0]    enc_idx;
    logic [MAX_V-1:0] new_bits;

    ccc_ram #(
        .WIDTH (MAX_V),
        .DEPTH (MAX_V)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    ccc_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_V)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    ccc_first_one #(
        .WIDTH (MAX_V)
    ) u_first_one (
        .vec   (enc_in),
        .found (enc_found),
        .idx   (enc_idx)
    );

    // vertex count in use, saturated to the matrix size
    assign n_eff = (CW'(num_vertices_reg) > CW'(MAX_V)) ? CW'(MAX_V) : CW'(num_vertices_reg);

    always_comb
    begin
        for (int i = 0; i < MAX_V; i++)
        begin
            active[i] = (CW'(i) < n_eff);
        end
    end

    assign busy     = (state_reg != ccc_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign edge_ok  = (CW'(vertex_a) < n_eff) && (CW'(vertex_b) < n_eff);
    assign new_bits = adj_rdata & ~visited_reg & active;
    assign enc_in   = (state_reg == ccc_pkg::ST_SCAN) ? (~visited_reg & active) : pend_reg;

    assign done            = done_reg;
    assign component_count = tally_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ccc_pkg::ST_CLEAR:
            begin
                if (clr_reg == AW'(MAX_V - 1))
                begin
                    state_next = ccc_pkg::ST_IDLE;
                end
            end
            ccc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        ccc_pkg::OP_ADD_EDGE:
                        begin
                            if (edge_ok)
                            begin
                                state_next = ccc_pkg::ST_EDGE_RD_A;
                            end
                        end
                        ccc_pkg::OP_COUNT: state_next = ccc_pkg::ST_SCAN;
                        ccc_pkg::OP_CLEAR: state_next = ccc_pkg::ST_CLEAR;
                        default:           state_next = ccc_pkg::ST_IDLE;
                    endcase
                end
            end
            ccc_pkg::ST_EDGE_RD_A: state_next = ccc_pkg::ST_EDGE_WR_A;
            ccc_pkg::ST_EDGE_WR_A: state_next = ccc_pkg::ST_EDGE_RD_B;
            ccc_pkg::ST_EDGE_RD_B: state_next = ccc_pkg::ST_EDGE_WR_B;
            ccc_pkg::ST_EDGE_WR_B: state_next = ccc_pkg::ST_IDLE;
            ccc_pkg::ST_SCAN:
            begin
                state_next = enc_found ? ccc_pkg::ST_PUSH : ccc_pkg::ST_IDLE;
            end
            ccc_pkg::ST_PUSH:
            begin
                if (!enc_found)
                begin
                    state_next = (depth_reg == '0) ? ccc_pkg::ST_SCAN : ccc_pkg::ST_POP;
                end
            end
            ccc_pkg::ST_POP:    state_next = ccc_pkg::ST_ROW;
            ccc_pkg::ST_ROW:    state_next = ccc_pkg::ST_EXPAND;
            ccc_pkg::ST_EXPAND: state_next = ccc_pkg::ST_PUSH;
            default:            state_next = ccc_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        clr_next     = clr_reg;
        depth_next   = depth_reg;
        tally_next   = tally_reg;
        done_next    = 1'b0;
        visited_next = visited_reg;
        pend_next    = pend_reg;
        va_next      = va_reg;
        vb_next      = vb_reg;
        adj_we       = 1'b0;
        adj_waddr    = clr_reg;
        adj_wdata    = '0;
        adj_raddr    = va_reg;
        stk_we       = 1'b0;
        stk_waddr    = depth_reg[AW-1:0];
        stk_wdata    = enc_idx;
        stk_raddr    = AW'(depth_reg - DW'(1));
        unique case (state_reg)
            ccc_pkg::ST_CLEAR:
            begin
                adj_we    = 1'b1;
                adj_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
            end
            ccc_pkg::ST_IDLE:
            begin
                va_next      = AW'(vertex_a);
                vb_next      = AW'(vertex_b);
                clr_next     = '0;
                visited_next = '0;
                depth_next   = '0;
                if (accept && (op == ccc_pkg::OP_COUNT))
                begin
                    tally_next = '0;
                end
            end
            ccc_pkg::ST_EDGE_RD_A:
            begin
                adj_raddr = va_reg;
            end
            ccc_pkg::ST_EDGE_WR_A:
            begin
                adj_we    = 1'b1;
                adj_waddr = va_reg;
                adj_wdata = adj_rdata | (ONE << vb_reg);
            end
            ccc_pkg::ST_EDGE_RD_B:
            begin
                adj_raddr = vb_reg;
            end
            ccc_pkg::ST_EDGE_WR_B:
            begin
                adj_we    = 1'b1;
                adj_waddr = vb_reg;
                adj_wdata = adj_rdata | (ONE << va_reg);
            end
            ccc_pkg::ST_SCAN:
            begin
                if (enc_found)
                begin
                    visited_next = visited_reg | (ONE << enc_idx);
                    pend_next    = ONE << enc_idx;
                    if (tally_reg != ccc_pkg::COUNT_MAX)
                    begin
                        tally_next = tally_reg + 7'd1;
                    end
                end
                else
                begin
                    done_next = 1'b1;
                end
            end
            ccc_pkg::ST_PUSH:
            begin
                if (enc_found)
                begin
                    stk_we     = 1'b1;
                    stk_waddr  = depth_reg[AW-1:0];
                    stk_wdata  = enc_idx;
                    depth_next = depth_reg + DW'(1);
                    pend_next  = pend_reg & ~(ONE << enc_idx);
                end
            end
            ccc_pkg::ST_POP:
            begin
                stk_raddr  = AW'(depth_reg - DW'(1));
                depth_next = depth_reg - DW'(1);
            end
            ccc_pkg::ST_ROW:
            begin
                adj_raddr = stk_rdata;
            end
            ccc_pkg::ST_EXPAND:
            begin
                visited_next = visited_reg | new_bits;
                pend_next    = new_bits;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ccc_pkg::ST_CLEAR;
            num_vertices_reg <= ccc_pkg::VERTICES_INIT;
            clr_reg          <= '0;
            depth_reg        <= '0;
            tally_reg        <= '0;
            done_reg         <= 1'b0;
            visited_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            depth_reg   <= depth_next;
            tally_reg   <= tally_next;
            done_reg    <= done_next;
            visited_reg <= visited_next;
            if (cfg_we)
            begin
                num_vertices_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        va_reg   <= va_next;
        vb_reg   <= vb_next;
    end

endmodule

[hdl/ccc_ram.sv]
// generic single-port-write ram with registered read
module ccc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/ccc_first_one.sv]
// priority encoder returning the lowest set bit of a vector
module ccc_first_one #(
    parameter int WIDTH = 64
) (
    input  logic [WIDTH-1:0]         vec,
    output logic                     found,
    output logic [$clog2(WIDTH)-1:0] idx
);

    localparam int IW = $clog2(WIDTH);

    always_comb
    begin
        idx   = '0;
        found = |vec;
        for (int i = WIDTH - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                idx = IW'(i);
            end
        end
    end

endmodule

[tb/sv/component_count_checker.sv]
// checker for the connected component counter: graph predictor and result compare
`timescale 1ns / 1ps
module component_count_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [1:0] op,
    input  logic [5:0] vertex_a,
    input  logic [5:0] vertex_b,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,
    input  logic       done,
    input  logic [6:0] component_count,
    input  logic       end_of_test,
    output int         mismatches,
    output int         outstanding
);

    logic [63:0] adjacency [64];
    logic [6:0]  vertex_setting;
    logic [6:0]  expected_counts [$];
    bit          leftover_checked;

    initial
    begin
        mismatches = 0;
        outstanding = 0;
        leftover_checked = 0;
    end

    function automatic int vertices_in_use();
        return (vertex_setting > 7'd64) ? 64 : int'(vertex_setting);
    endfunction

    // flood fill from each unseen vertex, restricted to the vertices in use
    function automatic logic [6:0] predict_component_count();
        logic [63:0] in_use;
        logic [63:0] seen;
        logic [63:0] frontier;
        logic [63:0] reach;
        logic [6:0]  tally;
        int          n;
        n = vertices_in_use();
        in_use = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        seen = '0;
        tally = '0;
        for (int v = 0; v < n; v++)
        begin
            if (!seen[v])
            begin
                frontier = 64'd1 << v;
                seen = seen | frontier;
                while (frontier != '0)
                begin
                    reach = '0;
                    for (int w = 0; w < 64; w++)
                    begin
                        if (frontier[w])
                            reach = reach | adjacency[w];
                    end
                    frontier = reach & in_use & ~seen;
                    seen = seen | frontier;
                end
                if (tally != ccc_pkg::COUNT_MAX)
                    tally = tally + 7'd1;
            end
        end
        return tally;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [6:0] wanted;
        if (!rst_n)
        begin
            for (int r = 0; r < 64; r++)
                adjacency[r] = '0;
            vertex_setting = ccc_pkg::VERTICES_INIT;
            expected_counts.delete();
            outstanding = 0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (expected_counts.size() == 0)
                begin
                    $display("%0t: component_count expected none, got %0d",
                             $time, component_count);
                    mismatches++;
                end
                else
                begin
                    wanted = expected_counts.pop_front();
                    if (component_count !== wanted)
                    begin
                        $display("%0t: component_count expected %0d, got %0d",
                                 $time, wanted, component_count);
                        mismatches++;
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                case (op)
                    ccc_pkg::OP_ADD_EDGE:
                    begin
                        if (int'(vertex_a) < vertices_in_use() &&
                            int'(vertex_b) < vertices_in_use())
                        begin
                            adjacency[vertex_a][vertex_b] = 1'b1;
                            adjacency[vertex_b][vertex_a] = 1'b1;
                        end
                    end
                    ccc_pkg::OP_COUNT:
                        expected_counts.push_back(predict_component_count());
                    ccc_pkg::OP_CLEAR:
                    begin
                        for (int r = 0; r < 64; r++)
                            adjacency[r] = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cfg_we === 1'b1)
                vertex_setting = cfg_wdata;
            outstanding = expected_counts.size();
            if (end_of_test && !leftover_checked)
            begin
                leftover_checked = 1;
                if (expected_counts.size() != 0)
                begin
                    $display("%0t: component_count expected %0d, got none (%0d left)",
                             $time, expected_counts[0], expected_counts.size());
                    mismatches += expected_counts.size();
                end
            end
        end
    end

endmodule

[tb/sv/tb_connected_component_counter.sv]
// testbench top for the connected component counter: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module tb_connected_component_counter;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ITEMS_PER_SETTING = 44;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [1:0] op = ccc_pkg::OP_ADD_EDGE;
    logic [5:0] vertex_a = '0;
    logic [5:0] vertex_b = '0;
    logic       cfg_we = 1'b0;
    logic [6:0] cfg_wdata = '0;
    logic       done;
    logic [6:0] component_count;
    logic       end_of_test = 1'b0;
    int         mismatches;
    int         outstanding;
    int         idle_pct = 0;
    int         quiet_cycles = 0;

    always #1 clk = ~clk;

    connected_component_counter DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .vertex_a        (vertex_a),
        .vertex_b        (vertex_b),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .done            (done),
        .component_count (component_count)
    );

    component_count_checker count_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .vertex_a        (vertex_a),
        .vertex_b        (vertex_b),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .done            (done),
        .component_count (component_count),
        .end_of_test     (end_of_test),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] kind, input logic [5:0] a,
                                input logic [5:0] b);
        @(negedge clk);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start = 1'b0;
            do
            begin
                @(negedge clk);
            end
            while ($urandom_range(0, 99) < idle_pct);
        end
        start = 1'b1;
        op = kind;
        vertex_a = a;
        vertex_b = b;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
    endtask

    // drop the request line, wait for pending count results and let edge and clear work finish
    task automatic wait_until_quiet();
        @(negedge clk);
        start = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_vertex_count(input logic [6:0] value);
        wait_until_quiet();
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [6:0] pick_vertex_count();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 7'd0;
        else if (r < 3)
            return 7'd64;
        else if (r == 3)
            return 7'd1;
        else if (r < 7)
            return 7'($urandom_range(2, 8));
        else if (r < 11)
            return 7'($urandom_range(2, 20));
        else if (r < 14)
            return 7'($urandom_range(1, 64));
        else
            return 7'($urandom_range(65, 127));
    endfunction

    task automatic random_request(input int n_eff);
        int r;
        r = $urandom_range(0, 99);
        if (r < 65 && n_eff > 0)
            send_request(ccc_pkg::OP_ADD_EDGE, 6'($urandom_range(0, n_eff - 1)),
                         6'($urandom_range(0, n_eff - 1)));
        else if (r < 72)
            send_request(ccc_pkg::OP_ADD_EDGE, 6'($urandom_range(0, 63)),
                         6'($urandom_range(0, 63)));
        else if (r < 88)
            send_request(ccc_pkg::OP_COUNT, 6'($urandom_range(0, 63)),
                         6'($urandom_range(0, 63)));
        else if (r < 94)
            send_request(ccc_pkg::OP_CLEAR, 6'($urandom_range(0, 63)),
                         6'($urandom_range(0, 63)));
        else
            send_request(OP_UNUSED, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
    endtask

    initial
    begin
        logic [6:0] setting;
        int         n_eff;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // reset size, corner vertices, duplicate edge, self loop, unused op
        send_request(ccc_pkg::OP_COUNT, 6'd0, 6'd0);
        send_request(ccc_pkg::OP_ADD_EDGE, 6'd0, 6'd63);
        send_request(ccc_pkg::OP_ADD_EDGE, 6'd63, 6'd0);
        send_request(ccc_pkg::OP_ADD_EDGE, 6'd5, 6'd5);
        send_request(ccc_pkg::OP_COUNT, 6'd63, 6'd63);
        send_request(OP_UNUSED, 6'd63, 6'd63);
        send_request(ccc_pkg::OP_ADD_EDGE, 6'd62, 6'd63);
        send_request(ccc_pkg::OP_COUNT, 6'd0, 6'd0);
        send_request(ccc_pkg::OP_CLEAR, 6'd63, 6'd0);
        send_request(ccc_pkg::OP_COUNT, 6'd0, 6'd0);
        set_vertex_count(7'd1);
        send_request(ccc_pkg::OP_ADD_EDGE, 6'd0, 6'd1);
        send_request(ccc_pkg::OP_ADD_EDGE, 6'd0, 6'd0);
        send_request(ccc_pkg::OP_COUNT, 6'd0, 6'd0);
        set_vertex_count(7'd0);
        send_request(ccc_pkg::OP_ADD_EDGE, 6'd0, 6'd0);
        send_request(ccc_pkg::OP_COUNT, 6'd0, 6'd0);
        set_vertex_count(7'd127);
        send_request(ccc_pkg::OP_ADD_EDGE, 6'd63, 6'd1);
        send_request(ccc_pkg::OP_COUNT, 6'd0, 6'd0);
        // edges touching the vertex limit are dropped
        set_vertex_count(7'd10);
        send_request(ccc_pkg::OP_ADD_EDGE, 6'd9, 6'd10);
        send_request(ccc_pkg::OP_ADD_EDGE, 6'd10, 6'd9);
        send_request(ccc_pkg::OP_ADD_EDGE, 6'd0, 6'd9);
        send_request(ccc_pkg::OP_COUNT, 6'd0, 6'd0);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1: idle_pct = 78;
                3: idle_pct = 10;
                default: idle_pct = 0;
            endcase
            for (int k = 0; k < 4; k++)
            begin
                setting = pick_vertex_count();
                n_eff = (setting > 7'd64) ? 64 : int'(setting);
                set_vertex_count(setting);
                repeat (ITEMS_PER_SETTING) random_request(n_eff);
            end
        end

        wait_until_quiet();
        end_of_test = 1'b1;
        @(posedge clk);
        @(negedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
